@@ rtl/row_correlation_matrix_defines.svh @@
// Assertion macros for the row correlation matrix block.
// Included by the module that carries concurrent assertions; no dependencies.
`ifndef ROW_CORRELATION_MATRIX_DEFINES_SVH
`define ROW_CORRELATION_MATRIX_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RCM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define RCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rcm_pkg.sv @@
// Shared constants, codes and types of the row correlation matrix block.
// No dependencies; every other file but the assertion macro header imports it.
package rcm_pkg;

   // Matrix geometry and sample format
   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLUMNS = 256;
   localparam int SAMPLE_BITS = 16;
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int COL_BITS    = $clog2(MAX_COLUMNS);
   localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
   localparam int RCFG_BITS   = 7;
   localparam int CCFG_BITS   = 9;
   localparam int CSR_BITS    = 9;

   // Arithmetic widths
   localparam int SUM_BITS    = SAMPLE_BITS + COL_BITS;
   localparam int PROD_BITS   = 2 * SAMPLE_BITS;
   localparam int SQ_BITS     = PROD_BITS + COL_BITS;
   localparam int VAR_BITS    = 50;
   localparam int RAD_BITS    = 62;
   localparam int ROOT_BITS   = RAD_BITS / 2;
   localparam int DEN_BITS    = 2 * ROOT_BITS;
   localparam int NUM_BITS    = 92;
   localparam int QUO_BITS    = 34;
   localparam int FRAC_BITS   = 30;
   localparam int EXP_BITS    = 5;
   localparam int SHIFT_BITS  = 7;
   localparam int CORR_BITS   = 32;

   localparam logic signed [CORR_BITS-1:0] CORR_ONE = CORR_BITS'(64'd1 << FRAC_BITS);

   // Request actions
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_ZERO_VAR = 2'd1;
   localparam logic [1:0] STAT_RANGE    = 2'd2;

   // Register indexes
   localparam logic CSR_ROWS    = 1'b0;
   localparam logic CSR_COLUMNS = 1'b1;

   // Status of an iterative arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

@@ rtl/rcm_channels.sv @@
// Request and response channel interfaces of the row correlation matrix.
// Depends on rcm_pkg for field widths.
interface rcm_req_if import rcm_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [ROW_BITS-1:0]           row_index;
   logic [COL_BITS-1:0]           column_index;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [ROW_BITS-1:0]           other_row;

   modport source(output valid, action, row_index, column_index, sample, other_row,
                  input ready);
   modport sink(input valid, action, row_index, column_index, sample, other_row,
                output ready);
endinterface

interface rcm_rsp_if import rcm_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [CORR_BITS-1:0] correlation;
   logic [1:0]                  status;

   modport source(output valid, correlation, status, input ready);
   modport sink(input valid, correlation, status, output ready);
endinterface

@@ rtl/rcm_store.sv @@
// Sample memory: one write port, two registered read ports.
// Depends on rcm_pkg for geometry.
module rcm_store import rcm_pkg::*; (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  logic [SAMPLE_BITS-1:0] wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_BITS-1:0]   rd_addr_a,
   input  logic [ADDR_BITS-1:0]   rd_addr_b,
   output logic [SAMPLE_BITS-1:0] rd_data_a,
   output logic [SAMPLE_BITS-1:0] rd_data_b
);

   logic [SAMPLE_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];
   logic [SAMPLE_BITS-1:0] rd_a_ff;
   logic [SAMPLE_BITS-1:0] rd_b_ff;

   // Write a loaded sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read both rows of one column
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/rcm_isqrt.sv @@
// Floor square root of a normalized radicand, one result bit per cycle.
// Depends on rcm_pkg for widths and the unit status type.
module rcm_isqrt import rcm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAD_BITS-1:0]  radicand,
   output logic [ROOT_BITS-1:0] root,
   output unit_status_type      status
);

   localparam int CNT_BITS = $clog2(ROOT_BITS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [RAD_BITS-1:0] val_ff;
   logic [RAD_BITS-1:0] res_ff;
   logic [RAD_BITS-1:0] bit_ff;
   logic [RAD_BITS:0]   trial;
   logic                last;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign last  = (count_ff == CNT_BITS'(ROOT_BITS - 1));

   // Track busy and the one-cycle done pulse
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && last) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Subtract the trial value when it fits, then move to the next digit pair
   always_ff @(posedge clock) begin
      if (start) begin
         val_ff   <= radicand;
         res_ff   <= '0;
         bit_ff   <= RAD_BITS'(1) << (RAD_BITS - 2);
         count_ff <= '0;
      end else if (busy_ff) begin
         if ({1'b0, val_ff} >= trial) begin
            val_ff <= val_ff - trial[RAD_BITS-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff   <= bit_ff >> 2;
         count_ff <= count_ff + CNT_BITS'(1);
      end
   end

   assign root        = res_ff[ROOT_BITS-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ rtl/rcm_divider.sv @@
// Restoring divider, one quotient bit per cycle, numerator taken MSB first.
// Depends on rcm_pkg for widths and the unit status type.
module rcm_divider import rcm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_BITS-1:0]  dividend,
   input  logic [DEN_BITS-1:0]  divisor,
   output logic [QUO_BITS-1:0]  quotient,
   output unit_status_type      status
);

   localparam int CNT_BITS = $clog2(NUM_BITS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [NUM_BITS-1:0] num_ff;
   logic [DEN_BITS-1:0] den_ff;
   logic [DEN_BITS-1:0] rem_ff;
   logic [QUO_BITS-1:0] quo_ff;
   logic [DEN_BITS:0]   rem_shift;
   logic                fits;
   logic                last;

   assign rem_shift = {rem_ff, num_ff[NUM_BITS-1]};
   assign fits      = (rem_shift >= {1'b0, den_ff});
   assign last      = (count_ff == CNT_BITS'(NUM_BITS - 1));

   // Track busy and the one-cycle done pulse
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && last) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Shift in one numerator bit, subtract the divisor when it fits
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff   <= dividend;
         den_ff   <= divisor;
         rem_ff   <= '0;
         quo_ff   <= '0;
         count_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= DEN_BITS'(rem_shift - {1'b0, den_ff});
         end else begin
            rem_ff <= rem_shift[DEN_BITS-1:0];
         end
         quo_ff   <= {quo_ff[QUO_BITS-2:0], fits};
         num_ff   <= num_ff << 1;
         count_ff <= count_ff + CNT_BITS'(1);
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ rtl/row_correlation_matrix.sv @@
// Row correlation matrix: sample store, column walk, and the sequencer of the
// finishing arithmetic. Depends on rcm_pkg, rcm_channels, rcm_store,
// rcm_isqrt, rcm_divider and row_correlation_matrix_defines.svh.
//
// Usage: requests arrive on req_if (valid/ready). A load request (action 0)
// writes one sample at (row_index, column_index); loads outside the rows or
// columns in use are dropped. A query request (action 1) names row_index and
// other_row and produces one response on rsp_if: the Pearson correlation as
// signed Q2.30 and a status (0 ok, 1 zero variance, 2 row out of range).
// Loads produce no response.
// A query walks the columns in use through the memory read ports, one column
// per cycle, then normalizes both variances, takes two 31-step square roots in
// parallel and runs a 92-step bit-serial divider. The next request is taken
// once the query is finished; a range failure skips the walk and arithmetic.
// The response sits in an output register; the block keeps taking loads while
// it waits, and a finished query holds until the receiver takes the previous
// response. Reset clears the control state and sets both registers to 1; the
// sample memory is not cleared and must be loaded before it is queried.
// Registers are written on csr_write_enable and must only change while idle.
`include "row_correlation_matrix_defines.svh"

module row_correlation_matrix import rcm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rcm_req_if.sink              req_if,
   rcm_rsp_if.source            rsp_if,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [CSR_BITS-1:0]  csr_write_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WALK  = 4'd1;
   localparam logic [3:0] ST_PROD1 = 4'd2;
   localparam logic [3:0] ST_PROD2 = 4'd3;
   localparam logic [3:0] ST_DIFF  = 4'd4;
   localparam logic [3:0] ST_NORM  = 4'd5;
   localparam logic [3:0] ST_ROOT  = 4'd6;
   localparam logic [3:0] ST_MULD  = 4'd7;
   localparam logic [3:0] ST_DIVGO = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [RCFG_BITS-1:0]  rows_cfg_ff;
   logic [CCFG_BITS-1:0]  cols_cfg_ff;
   logic [RCFG_BITS-1:0]  ny;
   logic [CCFG_BITS-1:0]  nx;

   logic                  req_fire;
   logic                  range_bad;
   logic                  load_ok;

   logic [ROW_BITS-1:0]   row_a_ff;
   logic [ROW_BITS-1:0]   row_b_ff;
   logic [CCFG_BITS-1:0]  col_ff;
   logic                  issue;
   logic                  rd_vld_ff;
   logic                  mul_vld_ff;
   logic [SAMPLE_BITS-1:0] rd_a, rd_b;

   logic signed [SAMPLE_BITS-1:0] a_ff, b_ff;
   logic signed [PROD_BITS-1:0]   paa_ff, pbb_ff, pab_ff;
   logic signed [SUM_BITS-1:0]    sa_ff, sb_ff;
   logic signed [SQ_BITS-1:0]     saa_ff, sbb_ff, sab_ff;

   logic signed [VAR_BITS-1:0]    nx_x, saa_x, sbb_x, sab_x, sa_x, sb_x;
   logic signed [VAR_BITS-1:0]    naa_ff, nbb_ff, nab_ff;
   logic signed [VAR_BITS-1:0]    qaa_ff, qbb_ff, qab_ff;
   logic signed [VAR_BITS-1:0]    va_w, vb_w, c_w;
   logic                          zero_var;

   logic                  negc_ff;
   logic [VAR_BITS-1:0]   cmag_ff;
   logic [RAD_BITS-1:0]   va_n_ff, vb_n_ff;
   logic [EXP_BITS-1:0]   ea_ff, eb_ff;
   logic                  norm_a, norm_b;
   logic                  root_start;
   logic [ROOT_BITS-1:0]  root_a, root_b;
   unit_status_type       root_stat_a, root_stat_b;

   logic [DEN_BITS-1:0]   den_ff;
   logic [NUM_BITS-1:0]   num_ff;
   logic [SHIFT_BITS-1:0] k_w;
   logic                  div_start;
   logic [QUO_BITS-1:0]   quo;
   unit_status_type       div_stat;
   logic [CORR_BITS-1:0]  mag_w;

   logic signed [CORR_BITS-1:0] res_corr_ff;
   logic [1:0]                  res_status_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [CORR_BITS-1:0] rsp_corr_ff;
   logic [1:0]                  rsp_status_ff;
   logic                        rsp_load;

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= RCFG_BITS'(1);
         cols_cfg_ff <= CCFG_BITS'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROWS:    rows_cfg_ff <= csr_write_data[RCFG_BITS-1:0];
            CSR_COLUMNS: cols_cfg_ff <= csr_write_data[CCFG_BITS-1:0];
            default:     rows_cfg_ff <= rows_cfg_ff;
         endcase
      end
   end

   // Clamp the registers to the supported geometry
   always_comb begin
      if (rows_cfg_ff == '0) begin
         ny = RCFG_BITS'(1);
      end else if (rows_cfg_ff > RCFG_BITS'(MAX_ROWS)) begin
         ny = RCFG_BITS'(MAX_ROWS);
      end else begin
         ny = rows_cfg_ff;
      end
      if (cols_cfg_ff == '0) begin
         nx = CCFG_BITS'(1);
      end else if (cols_cfg_ff > CCFG_BITS'(MAX_COLUMNS)) begin
         nx = CCFG_BITS'(MAX_COLUMNS);
      end else begin
         nx = cols_cfg_ff;
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign range_bad    = (RCFG_BITS'(req_if.row_index) >= ny) ||
                         (RCFG_BITS'(req_if.other_row) >= ny);
   assign load_ok      = req_fire && (req_if.action == ACTION_LOAD) &&
                         (RCFG_BITS'(req_if.row_index) < ny) &&
                         (CCFG_BITS'(req_if.column_index) < nx);

   // Sample memory
   assign issue = (state_ff == ST_WALK) && (col_ff < nx);

   rcm_store u_store (
      .clock     (clock),
      .wr_en     (load_ok),
      .wr_addr   ({req_if.row_index, req_if.column_index}),
      .wr_data   (req_if.sample),
      .rd_en     (issue),
      .rd_addr_a ({row_a_ff, col_ff[COL_BITS-1:0]}),
      .rd_addr_b ({row_b_ff, col_ff[COL_BITS-1:0]}),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.action == ACTION_QUERY)) begin
               state_in = range_bad ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if ((col_ff == nx) && !rd_vld_ff && !mul_vld_ff) begin
               state_in = ST_PROD1;
            end
         end
         ST_PROD1: state_in = ST_PROD2;
         ST_PROD2: state_in = ST_DIFF;
         ST_DIFF:  state_in = zero_var ? ST_DONE : ST_NORM;
         ST_NORM: begin
            if (root_start) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_stat_a.done) begin
               state_in = ST_MULD;
            end
         end
         ST_MULD:  state_in = ST_DIVGO;
         ST_DIVGO: state_in = ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Walk the columns: address, read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         row_a_ff <= req_if.row_index;
         row_b_ff <= req_if.other_row;
         col_ff   <= '0;
         sa_ff    <= '0;
         sb_ff    <= '0;
         saa_ff   <= '0;
         sbb_ff   <= '0;
         sab_ff   <= '0;
      end else begin
         if (issue) begin
            col_ff <= col_ff + CCFG_BITS'(1);
         end
         if (mul_vld_ff) begin
            sa_ff  <= sa_ff + SUM_BITS'(a_ff);
            sb_ff  <= sb_ff + SUM_BITS'(b_ff);
            saa_ff <= saa_ff + SQ_BITS'(paa_ff);
            sbb_ff <= sbb_ff + SQ_BITS'(pbb_ff);
            sab_ff <= sab_ff + SQ_BITS'(pab_ff);
         end
      end
      if (rd_vld_ff) begin
         a_ff   <= $signed(rd_a);
         b_ff   <= $signed(rd_b);
         paa_ff <= $signed(rd_a) * $signed(rd_a);
         pbb_ff <= $signed(rd_b) * $signed(rd_b);
         pab_ff <= $signed(rd_a) * $signed(rd_b);
      end
   end

   // Form n*S2 and S1*S1 products, then the differences
   assign nx_x  = $signed(VAR_BITS'(nx));
   assign saa_x = VAR_BITS'(saa_ff);
   assign sbb_x = VAR_BITS'(sbb_ff);
   assign sab_x = VAR_BITS'(sab_ff);
   assign sa_x  = VAR_BITS'(sa_ff);
   assign sb_x  = VAR_BITS'(sb_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_PROD1) begin
         naa_ff <= nx_x * saa_x;
         nbb_ff <= nx_x * sbb_x;
         nab_ff <= nx_x * sab_x;
      end
      if (state_ff == ST_PROD2) begin
         qaa_ff <= sa_x * sa_x;
         qbb_ff <= sb_x * sb_x;
         qab_ff <= sa_x * sb_x;
      end
   end

   assign va_w     = naa_ff - qaa_ff;
   assign vb_w     = nbb_ff - qbb_ff;
   assign c_w      = nab_ff - qab_ff;
   assign zero_var = (va_w == '0) || (vb_w == '0);

   // Normalize each variance into [2^60, 2^62) by even shifts
   assign norm_a     = (va_n_ff[RAD_BITS-1:RAD_BITS-2] != 2'b00);
   assign norm_b     = (vb_n_ff[RAD_BITS-1:RAD_BITS-2] != 2'b00);
   assign root_start = (state_ff == ST_NORM) && norm_a && norm_b;

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIFF) begin
         negc_ff <= c_w[VAR_BITS-1];
         cmag_ff <= c_w[VAR_BITS-1] ? VAR_BITS'(-c_w) : VAR_BITS'(c_w);
         va_n_ff <= RAD_BITS'(unsigned'(va_w));
         vb_n_ff <= RAD_BITS'(unsigned'(vb_w));
         ea_ff   <= '0;
         eb_ff   <= '0;
      end else if (state_ff == ST_NORM) begin
         if (!norm_a) begin
            va_n_ff <= va_n_ff << 2;
            ea_ff   <= ea_ff + EXP_BITS'(1);
         end
         if (!norm_b) begin
            vb_n_ff <= vb_n_ff << 2;
            eb_ff   <= eb_ff + EXP_BITS'(1);
         end
      end
   end

   // Square roots of both normalized variances
   rcm_isqrt u_root_a (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (va_n_ff),
      .root     (root_a),
      .status   (root_stat_a)
   );

   rcm_isqrt u_root_b (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (vb_n_ff),
      .root     (root_b),
      .status   (root_stat_b)
   );

   // Divisor and scaled numerator
   assign k_w = SHIFT_BITS'(FRAC_BITS) + SHIFT_BITS'(ea_ff) + SHIFT_BITS'(eb_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_MULD) begin
         den_ff <= DEN_BITS'(root_a) * DEN_BITS'(root_b);
         num_ff <= NUM_BITS'(cmag_ff) << k_w;
      end
   end

   assign div_start = (state_ff == ST_DIVGO);

   rcm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (den_ff),
      .quotient (quo),
      .status   (div_stat)
   );

   // Cap the magnitude at one and apply the sign of the covariance
   assign mag_w = (quo > QUO_BITS'(CORR_ONE)) ? CORR_ONE : CORR_BITS'(quo);

   always_ff @(posedge clock) begin
      if (req_fire && (req_if.action == ACTION_QUERY) && range_bad) begin
         res_corr_ff   <= '0;
         res_status_ff <= STAT_RANGE;
      end else if ((state_ff == ST_DIFF) && zero_var) begin
         res_corr_ff   <= '0;
         res_status_ff <= STAT_ZERO_VAR;
      end else if ((state_ff == ST_DIV) && div_stat.done) begin
         res_corr_ff   <= negc_ff ? -$signed(mag_w) : $signed(mag_w);
         res_status_ff <= STAT_OK;
      end
   end

   // Response register: load when empty or being drained
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_corr_ff   <= res_corr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.correlation = rsp_corr_ff;
   assign rsp_if.status      = rsp_status_ff;

   // Checks
   `RCM_ASSERT_IMP(a_busy_blocks_req, clock, reset, state_ff != ST_IDLE,
                   !req_if.ready, "request taken while busy")
   `RCM_ASSERT_IMP(a_flag_zero, clock, reset,
                   rsp_if.valid && (rsp_if.status != STAT_OK),
                   rsp_if.correlation == '0, "flagged response with nonzero value")
   `RCM_ASSERT_IMP(a_corr_range, clock, reset, rsp_if.valid,
                   (rsp_if.correlation <= CORR_ONE) && (rsp_if.correlation >= -CORR_ONE),
                   "correlation beyond one")
   `RCM_ASSERT_NEXT(a_div_runs, clock, reset, state_ff == ST_DIVGO,
                    div_stat.busy && !root_stat_b.busy, "divider not running after start")

endmodule
